@@ hdl/ppmfd_pkg.sv @@
// Package for the PPM frame decoder: sizes, register indexes, report kinds.
// Used by ppm_frame_decoder; no dependencies.
`default_nettype none

package ppmfd_pkg;

  // Channel slots held by the decoder
  localparam int MAX_CHANNELS = 14;
  localparam int CH_IDX_W     = $clog2(MAX_CHANNELS + 1);
  localparam int POS_IDX_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Field widths
  localparam int CNT_W       = 16;
  localparam int CHAN_W      = 4;
  localparam int KIND_W      = 2;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;

  // Reset values
  localparam logic [CNT_W-1:0] WRAP_TOP_RST  = 16'd60005;
  localparam logic [CNT_W-1:0] FRAME_GAP_RST = 16'd8000;
  localparam logic [CNT_W-1:0] MIN_WIDTH_RST = 16'd1500;
  localparam logic [CNT_W-1:0] MAX_WIDTH_RST = 16'd4500;
  localparam logic [CNT_W-1:0] CENTER_POS    = 16'd3000;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WRAP_TOP  = 2'd0,
    REG_FRAME_GAP = 2'd1,
    REG_MIN_WIDTH = 2'd2,
    REG_MAX_WIDTH = 2'd3
  } cfg_reg_t;

  // Report kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME    = 2'd0,
    KIND_STORED   = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_READ     = 2'd3
  } report_kind_t;

  // Input item function
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_READ = 1'b1;

endpackage

`default_nettype wire

@@ hdl/ppm_frame_decoder.sv @@
// PPM frame decoder: classifies tick gaps between rising edges, stores channel
// positions and answers position reads. Uses ppmfd_pkg.
// Each accepted word's result is registered in the output register.
// Throughput: one word per cycle; the input stalls only while a result sits untaken.
// Reset (rst, synchronous): config to defaults, counter/index/count to zero,
// all positions to center; no clearing pass.
`default_nettype none

module ppm_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [ppmfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ppmfd_pkg::CNT_W-1:0]      cfg_wdata,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [ppmfd_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // rising_edge, read_channel[3:0], pad
  input  wire logic        s_axis_tuser,                       // func
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [ppmfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // channel[3:0], width[15:0], ch_total[3:0]
  output logic [ppmfd_pkg::KIND_W-1:0]     m_axis_tuser   // report_kind[1:0]
);

  // configuration registers
  logic [ppmfd_pkg::CNT_W-1:0] wrap_top, frame_gap, min_width, max_width;

  // decoder state
  logic [ppmfd_pkg::CNT_W-1:0]    interval_counter, interval_counter_next;
  logic [ppmfd_pkg::CH_IDX_W-1:0] channel_index, channel_index_next;
  logic [ppmfd_pkg::CH_IDX_W-1:0] frame_channels, frame_channels_next;
  logic [ppmfd_pkg::CNT_W-1:0]    positions [ppmfd_pkg::MAX_CHANNELS];

  // input fields
  logic                        in_func;
  logic                        in_edge;
  logic [ppmfd_pkg::CHAN_W-1:0] in_rd;
  logic                        accept;

  // result computation
  logic                          res_valid;
  ppmfd_pkg::report_kind_t       res_kind;
  logic [ppmfd_pkg::CHAN_W-1:0]  res_chan;
  logic [ppmfd_pkg::CNT_W-1:0]   res_width;
  logic [ppmfd_pkg::CH_IDX_W-1:0] res_count;
  logic                          pos_we;
  logic [ppmfd_pkg::POS_IDX_W-1:0] pos_slot;
  logic [ppmfd_pkg::CH_IDX_W-1:0] idx_inc;
  logic [ppmfd_pkg::CH_IDX_W-1:0] slot_full;

  // output register
  logic                          out_valid;
  ppmfd_pkg::report_kind_t       out_kind;
  logic [ppmfd_pkg::CHAN_W-1:0]  out_chan;
  logic [ppmfd_pkg::CNT_W-1:0]   out_width;
  logic [ppmfd_pkg::CHAN_W-1:0]  out_count;

  assign in_func = s_axis_tuser;
  assign in_edge = s_axis_tdata[0];
  assign in_rd   = s_axis_tdata[4:1];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_top  <= ppmfd_pkg::WRAP_TOP_RST;
      frame_gap <= ppmfd_pkg::FRAME_GAP_RST;
      min_width <= ppmfd_pkg::MIN_WIDTH_RST;
      max_width <= ppmfd_pkg::MAX_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (ppmfd_pkg::cfg_reg_t'(cfg_addr))
        ppmfd_pkg::REG_WRAP_TOP:  wrap_top  <= cfg_wdata;
        ppmfd_pkg::REG_FRAME_GAP: frame_gap <= cfg_wdata;
        ppmfd_pkg::REG_MIN_WIDTH: min_width <= cfg_wdata;
        ppmfd_pkg::REG_MAX_WIDTH: max_width <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick / edge classification and read lookup
  always_comb begin
    interval_counter_next = interval_counter;
    channel_index_next    = channel_index;
    frame_channels_next   = frame_channels;
    res_valid = 1'b0;
    res_kind  = ppmfd_pkg::KIND_READ;
    res_chan  = in_rd;
    res_width = '0;
    res_count = frame_channels;
    pos_we    = 1'b0;
    idx_inc   = channel_index;
    slot_full = '0;
    pos_slot  = '0;

    if (in_func == ppmfd_pkg::FUNC_READ) begin
      res_valid = 1'b1;
      if (32'(in_rd) < ppmfd_pkg::MAX_CHANNELS)
        res_width = positions[in_rd[ppmfd_pkg::POS_IDX_W-1:0]];
    end else begin
      // counter advance with wrap
      if (interval_counter >= wrap_top)
        interval_counter_next = '0;
      else
        interval_counter_next = interval_counter + 1'b1;

      if (in_edge) begin
        res_valid = 1'b1;
        res_width = interval_counter_next;
        interval_counter_next = '0;
        // saturating channel step
        if (32'(channel_index) < ppmfd_pkg::MAX_CHANNELS)
          idx_inc = channel_index + 1'b1;
        slot_full = idx_inc - 1'b1;
        pos_slot  = slot_full[ppmfd_pkg::POS_IDX_W-1:0];
        channel_index_next = idx_inc;

        if (res_width > frame_gap) begin
          res_kind  = ppmfd_pkg::KIND_FRAME;
          res_chan  = '0;
          frame_channels_next = idx_inc;
          res_count = idx_inc;
          channel_index_next = '0;
        end else if (res_width > min_width && res_width < max_width) begin
          res_kind = ppmfd_pkg::KIND_STORED;
          res_chan = ppmfd_pkg::CHAN_W'(slot_full);
          pos_we   = 1'b1;
        end else begin
          res_kind = ppmfd_pkg::KIND_REJECTED;
          res_chan = ppmfd_pkg::CHAN_W'(slot_full);
        end
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_counter <= '0;
      channel_index    <= '0;
      frame_channels   <= '0;
    end else if (accept) begin
      interval_counter <= interval_counter_next;
      channel_index    <= channel_index_next;
      frame_channels   <= frame_channels_next;
    end
  end

  // stored positions
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppmfd_pkg::MAX_CHANNELS; i++)
        positions[i] <= ppmfd_pkg::CENTER_POS;
    end else if (accept && pos_we) begin
      positions[pos_slot] <= res_width;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind  <= res_kind;
      out_chan  <= res_chan;
      out_width <= res_width;
      out_count <= ppmfd_pkg::CHAN_W'(res_count);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {out_count, out_width, out_chan};

`ifndef SYNTHESIS
  // input never stalls while the output register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // a read or an edge always produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tdata[0])) |=> m_axis_tvalid)
    else $error("result missing after read or edge");

  // channel index never exceeds MAX_CHANNELS
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    32'(channel_index) <= ppmfd_pkg::MAX_CHANNELS)
    else $error("channel index out of range");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for ppm_frame_decoder: drives tick and read words,
// predicts every report from its own decoder model, and checks each result word.
// Depends on ppmfd_pkg and ppm_frame_decoder.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ppmfd_pkg::*;

  typedef struct packed {
    report_kind_t     kind;
    logic [3:0]       chan;
    logic [CNT_W-1:0] width;
    logic [3:0]       count;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_WRAP_TOP;
  logic [CNT_W-1:0]      cfg_wdata = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // rising_edge, read_channel[3:0], pad
  logic                  s_axis_tuser = FUNC_TICK;  // func

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // channel[3:0], width[15:0], ch_total[3:0]
  logic [KIND_W-1:0]     m_axis_tuser;  // report_kind[1:0]

  ppm_frame_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder model state
  logic [CNT_W-1:0] wrap_top_q, frame_gap_q, min_width_q, max_width_q;
  logic [CNT_W-1:0] tick_count;
  logic [3:0]       chan_idx;
  logic [3:0]       frame_chans;
  logic [CNT_W-1:0] stored_pos [MAX_CHANNELS];

  report_t pending_reports [$];
  int      err_cnt = 0;
  int      words_sent = 0;
  int      src_idle_pct = 0;
  int      dst_stall_pct = 0;

  function automatic void reset_decoder();
    wrap_top_q  = WRAP_TOP_RST;
    frame_gap_q = FRAME_GAP_RST;
    min_width_q = MIN_WIDTH_RST;
    max_width_q = MAX_WIDTH_RST;
    tick_count  = '0;
    chan_idx    = '0;
    frame_chans = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) stored_pos[i] = CENTER_POS;
  endfunction

  function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CNT_W-1:0] val);
    case (cfg_reg_t'(idx))
      REG_WRAP_TOP:  wrap_top_q  = val;
      REG_FRAME_GAP: frame_gap_q = val;
      REG_MIN_WIDTH: min_width_q = val;
      REG_MAX_WIDTH: max_width_q = val;
      default: ;
    endcase
  endfunction

  // Works out the report (if any) of one accepted word and queues it
  function automatic void decode_word(logic func, logic rise, logic [3:0] rd_chan);
    logic [CNT_W-1:0] gap;
    logic [3:0]       slot;
    report_t          r;
    if (func == FUNC_READ) begin
      r.kind  = KIND_READ;
      r.chan  = rd_chan;
      r.width = '0;
      if (rd_chan < MAX_CHANNELS) r.width = stored_pos[rd_chan];
      r.count = frame_chans;
      pending_reports.push_back(r);
      return;
    end
    // counter wraps once it sits at or above the top
    if (tick_count >= wrap_top_q) tick_count = '0;
    else tick_count = tick_count + 1'b1;
    if (!rise) return;
    gap = tick_count;
    tick_count = '0;
    if (chan_idx < MAX_CHANNELS) chan_idx = chan_idx + 1'b1;
    if (gap > frame_gap_q) begin
      frame_chans = chan_idx;
      chan_idx    = '0;
      r.kind = KIND_FRAME;
      r.chan = '0;
    end else begin
      slot   = chan_idx - 1'b1;
      r.chan = slot;
      if (gap > min_width_q && gap < max_width_q && slot < MAX_CHANNELS) begin
        stored_pos[slot] = gap;
        r.kind = KIND_STORED;
      end else begin
        r.kind = KIND_REJECTED;
      end
    end
    r.width = gap;
    r.count = frame_chans;
    pending_reports.push_back(r);
  endfunction

  // Monitor: check taken result words, then model accepted words and writes
  always @(posedge clk) begin
    report_t got, want;
    if (rst) begin
      reset_decoder();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = report_kind_t'(m_axis_tuser);
        got.chan  = m_axis_tdata[3:0];
        got.width = m_axis_tdata[19:4];
        got.count = m_axis_tdata[23:20];
        if (pending_reports.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result word: kind %0d chan %0d width %0d count %0d",
                     got.kind, got.chan, got.width, got.count);
        end else begin
          want = pending_reports.pop_front();
          if (got.kind !== want.kind || got.chan !== want.chan ||
              got.width !== want.width || got.count !== want.count) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch (exp/got): kind %0d/%0d chan %0d/%0d width %0d/%0d count %0d/%0d",
                       want.kind, got.kind, want.chan, got.chan,
                       want.width, got.width, want.count, got.count);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        decode_word(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[4:1]);
      if (cfg_we) apply_reg(cfg_addr, cfg_wdata);
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    m_axis_tready <= (dst_stall_pct == 0) || ($urandom_range(99) >= dst_stall_pct);
  end

  // Sends one word; returns at the edge where it was taken, tvalid still high
  task automatic send_word(input logic func, input logic rise, input logic [3:0] rd_chan);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {3'b000, rd_chan, rise};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  // Gap of g ticks: g-1 plain ticks, then a tick carrying the rising edge
  task automatic send_pulse(input int g);
    for (int i = 1; i < g; i++) send_word(FUNC_TICK, 1'b0, 4'($urandom_range(15)));
    send_word(FUNC_TICK, 1'b1, 4'($urandom_range(15)));
  endtask

  // Hold the input until every queued report is out, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= 16'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input int wt, input int fg, input int mn, input int mx);
    cfg_reg_t idx [4];
    int       val [4];
    idx = '{REG_WRAP_TOP, REG_FRAME_GAP, REG_MIN_WIDTH, REG_MAX_WIDTH};
    val = '{wt, fg, mn, mx};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= 16'(val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Reset values, reads out of range, then each report kind on a short config
  task automatic test_directed();
    send_word(FUNC_READ, 1'b0, 4'd0);
    send_word(FUNC_READ, 1'b0, 4'd13);
    send_word(FUNC_READ, 1'b1, 4'd14);
    send_word(FUNC_READ, 1'b1, 4'd15);
    send_pulse(2);                       // far below min width: rejected
    drain();
    set_config(30, 4, 1, 4);
    send_pulse(6);                       // frame start
    send_pulse(1);                       // on the lower bound: rejected
    send_pulse(2);
    send_pulse(3);
    send_pulse(4);                       // on the upper bound: rejected
    send_word(FUNC_READ, 1'b0, 4'd1);
    send_word(FUNC_READ, 1'b0, 4'd2);
    drain();
  endtask

  // Wrap top of zero, of one, and lowered under a running count
  task automatic test_wrap_limits();
    set_config(0, 4, 1, 4);
    send_pulse(4);
    send_pulse(1);
    drain();
    set_config(1, 0, 0, 2);
    repeat (6) send_pulse($urandom_range(1, 4));
    drain();
    set_config(100, 50, 1, 40);
    repeat (30) send_word(FUNC_TICK, 1'b0, 4'd0);
    drain();
    write_reg(REG_WRAP_TOP, 10);
    send_pulse(1);
    send_pulse(12);
    drain();
  endtask

  // Full-range wrap top with the widest accepting bounds
  task automatic test_long_gap();
    set_config(65535, 65534, 0, 65535);
    send_pulse(40);                      // well inside the wide bounds: stored
    send_pulse(1);
    send_word(FUNC_READ, 1'b0, 4'd0);
    drain();
    write_reg(REG_FRAME_GAP, 30);
    send_pulse(31);                      // just above the gap: frame start
    send_pulse(30);                      // on the gap: stored
    send_word(FUNC_READ, 1'b0, 4'd0);
    drain();
  endtask

  // Mostly well-formed frames with random content, some noise and broken runs
  task automatic run_frames(input int wt, input int fg, input int mn, input int mx,
                            input int src_pct, input int dst_pct, input int n_words);
    int start, lo, hi, g, nch;
    set_config(wt, fg, mn, mx);
    src_idle_pct  = src_pct;
    dst_stall_pct = dst_pct;
    start = words_sent;
    lo = mn + 1;
    hi = mx - 1;
    while (words_sent - start < n_words) begin
      if ($urandom_range(99) < 80) begin
        send_pulse(fg + 1 + $urandom_range(4));
        nch = $urandom_range(1, MAX_CHANNELS + 2);
        for (int c = 0; c < nch; c++) begin
          if ($urandom_range(9) == 0)
            send_word(FUNC_READ, 1'($urandom_range(1)), 4'($urandom_range(15)));
          if (hi < lo || hi > 40 || $urandom_range(9) == 0) g = $urandom_range(1, 16);
          else g = $urandom_range(lo, hi);
          send_pulse(g);
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(9) < 4)
            send_word(FUNC_READ, 1'($urandom_range(1)), 4'($urandom_range(15)));
          else
            send_word(FUNC_TICK, 1'($urandom_range(1)), 4'($urandom_range(15)));
        end
      end
      if ($urandom_range(49) == 0) drain();
    end
    drain();
    src_idle_pct  = 0;
    dst_stall_pct = 0;
  endtask

  task automatic test_random();
    run_frames(24, 10, 2, 7, 0, 0, 250);
    run_frames(24, 10, 2, 7, 86, 0, 200);
    run_frames(30, 12, 3, 9, 0, 86, 200);
    run_frames(20, 8, 1, 6, 26, 26, 200);
    run_frames(9, 12, 1, 6, 26, 26, 120);     // top under the gap: no frames, index saturates
    run_frames(50, 0, 0, 65535, 0, 0, 100);   // every nonzero gap starts a frame
    run_frames(24, 10, 7, 3, 26, 26, 100);    // inverted bounds
    run_frames(24, 10, 4, 5, 86, 86, 80);     // touching bounds
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_wrap_limits();
    test_long_gap();
    test_random();
    drain();
    err_cnt += pending_reports.size();
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ ppm_frame_decoder.f @@
hdl/ppmfd_pkg.sv
hdl/ppm_frame_decoder.sv
verif/tb_top.sv
